// ===== design/wjd_pkg.sv =====
package wjd_pkg;

   // Depth of the command history; the window length saturates to it.
   localparam int MAX_WINDOW = 256;
   localparam int PTR_W      = $clog2(MAX_WINDOW);
   localparam int LEN_W      = PTR_W + 1;

   localparam int CMD_W      = 16;
   localparam int OUT_SUM_W  = 24;
   localparam int THR_W      = 23;
   localparam int WLEN_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   // The internal sum is exact for a full window of extreme commands.
   localparam int SUM_W = (CMD_W + 1 + PTR_W > OUT_SUM_W) ? CMD_W + 1 + PTR_W : OUT_SUM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JAM_THRESHOLD = 2'd2;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd50;
   localparam logic [THR_W-1:0]  THR_RESET  = 23'd8388607;

endpackage

// ===== design/windowed_effort_jam_detector_core.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_effort_command
// rsp_      out        rsp_valid/rsp_stall  rsp_jam_detected, rsp_window_sum
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle is sustained while the result side does not stall; each result is
// presented once its request has been registered (the history is read as it is registered)
// and the sum update has then loaded the result register.
// The history memory has one write and one registered read port each cycle.
// Reset is synchronous; it clears the history valid bits, pointer and sum at once.
// A stalled result holds the pipeline; the request side stalls only once both stages are full.
module windowed_effort_jam_detector_core
   import wjd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [CMD_W-1:0]      req_effort_command,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_jam_detected,
   output logic signed [OUT_SUM_W-1:0]  rsp_window_sum,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(8388608);

   logic                      enable_ff;
   logic [WLEN_W-1:0]         win_len_ff;
   logic [THR_W-1:0]          threshold_ff;

   logic signed [CMD_W-1:0]   history_mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]     hist_vld_ff;
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;

   logic                      s1_valid_ff;
   logic signed [CMD_W-1:0]   s1_cmd_ff;
   logic [PTR_W-1:0]          s1_ptr_ff;
   logic signed [CMD_W-1:0]   s1_rd_data_ff;
   logic                      s1_rd_vld_ff;
   logic                      s1_byp_ff;
   logic signed [CMD_W-1:0]   s1_byp_data_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_jam_ff;
   logic signed [OUT_SUM_W-1:0] rsp_sum_ff;

   logic                      csr_wr;
   logic                      clear_win;
   logic                      out_free;
   logic                      s1_adv;
   logic                      req_acc;
   logic                      hist_wr;
   logic [LEN_W-1:0]          eff_len;
   logic [PTR_W-1:0]          cur_ptr;
   logic signed [CMD_W-1:0]   old_cmd;
   logic                      jam_in;
   logic signed [SUM_W-1:0]   sum_sat;
   logic signed [SUM_W-1:0]   thr_ext;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign clear_win = csr_wr & ((csr_index == CSR_DETECT_ENABLE) ||
                                (csr_index == CSR_WINDOW_LENGTH));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_acc   = req_valid && !req_stall;
   assign hist_wr   = s1_adv && enable_ff;

   // A length of zero behaves as one; anything beyond the store depth saturates.
   always_comb begin
      if (win_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (int'(win_len_ff) > MAX_WINDOW) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = LEN_W'(win_len_ff);
      end
   end

   always_comb begin
      cur_ptr   = ({1'b0, wr_ptr_ff} >= eff_len) ? '0 : wr_ptr_ff;
      wr_ptr_in = (({1'b0, cur_ptr} + LEN_W'(1)) < eff_len) ? cur_ptr + PTR_W'(1) : '0;
   end

   // The entry being overwritten: forwarded if it was written as this request was read.
   always_comb begin
      if (s1_byp_ff) begin
         old_cmd = s1_byp_data_ff;
      end else if (s1_rd_vld_ff) begin
         old_cmd = s1_rd_data_ff;
      end else begin
         old_cmd = '0;
      end
   end

   always_comb begin
      thr_ext = SUM_W'({1'b0, threshold_ff});
      if (enable_ff) begin
         sum_in = sum_ff + SUM_W'(s1_cmd_ff) - SUM_W'(old_cmd);
         jam_in = (sum_in >= thr_ext);
      end else begin
         sum_in = sum_ff;
         jam_in = 1'b0;
      end
      if (sum_in > SUM_HI) begin
         sum_sat = SUM_HI;
      end else if (sum_in < SUM_LO) begin
         sum_sat = SUM_LO;
      end else begin
         sum_sat = sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_wr) begin
         history_mem[s1_ptr_ff] <= s1_cmd_ff;
      end
      if (req_acc) begin
         s1_rd_data_ff  <= history_mem[cur_ptr];
         s1_rd_vld_ff   <= hist_vld_ff[cur_ptr];
         s1_byp_ff      <= hist_wr && (s1_ptr_ff == cur_ptr);
         s1_byp_data_ff <= s1_cmd_ff;
         s1_cmd_ff      <= req_effort_command;
         s1_ptr_ff      <= cur_ptr;
      end
      if (s1_adv) begin
         rsp_jam_ff <= jam_in;
         rsp_sum_ff <= sum_sat[OUT_SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         win_len_ff   <= WLEN_RESET;
         threshold_ff <= THR_RESET;
         hist_vld_ff  <= '0;
         wr_ptr_ff    <= '0;
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               CSR_DETECT_ENABLE: enable_ff    <= csr_wdata[0];
               CSR_WINDOW_LENGTH: win_len_ff   <= csr_wdata[WLEN_W-1:0];
               CSR_JAM_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (clear_win) begin
            hist_vld_ff <= '0;
            wr_ptr_ff   <= '0;
            sum_ff      <= '0;
         end else begin
            if (hist_wr) begin
               hist_vld_ff[s1_ptr_ff] <= 1'b1;
            end
            if (req_acc && enable_ff) begin
               wr_ptr_ff <= wr_ptr_in;
            end
            if (s1_adv) begin
               sum_ff <= sum_in;
            end
         end
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_jam_detected = rsp_jam_ff;
   assign rsp_window_sum   = rsp_sum_ff;

endmodule
